### sv/pas_pkg.sv
// Shared types and constants of the pedal ADC scaler.
`default_nettype none

package pas_pkg;

	// Field widths fixed by the interface.
	localparam int PEDAL_W = 2;
	localparam int ADC_W = 12;
	localparam int TIME_W = 32;
	localparam int VAL_W = 7;

	// Pedal and window sizing. WINDOW_DEPTH must be a power of two so that
	// the average is a plain shift of the window sum.
	localparam int PEDAL_COUNT = 3;
	localparam int WINDOW_DEPTH = 16;
	localparam int CAL_PEDALS = 3;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;
	localparam int MIN_GAP_MS = 20;

	// Scaling arithmetic: the sample is widened by 4 bits, end points by 9 bits.
	localparam int ADC_SHIFT = 4;
	localparam int CAL_SHIFT = 9;
	localparam int WIDE_W = ADC_W + ADC_SHIFT;
	localparam int DIVD_W = WIDE_W - 2;
	localparam int DIVS_W = VAL_W;
	localparam int REM_W = DIVS_W + 1;
	localparam int DIV_STEPS = DIVD_W;
	localparam int DSTEP_W = $clog2(DIV_STEPS + 1);

	// Window storage.
	localparam int WPTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = $clog2(WINDOW_DEPTH * (2 ** VAL_W - 1) + 1);
	localparam int AVG_SHIFT = $clog2(WINDOW_DEPTH);
	localparam int MEM_DEPTH = PEDAL_COUNT * WINDOW_DEPTH;
	localparam int MEM_AW = $clog2(MEM_DEPTH);

	// Configuration register map: index 2N is the A end point of pedal N,
	// index 2N+1 the B end point.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_REG_COUNT = 2 * CAL_PEDALS;
	localparam logic CFG_SEL_HIGH = 1'b1;

	// Work queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [PEDAL_W-1:0] pedal;
		logic [DIVD_W-1:0]  dividend;
		logic [DIVS_W-1:0]  divisor;
		logic               inv;
		logic [TIME_W-1:0]  now_ms;
	} pas_work_t;

endpackage

`default_nettype wire

### sv/pas_front.sv
// Front end: calibration registers, sample acceptance and range classification.
`default_nettype none

module pas_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            q_full,
	input  logic [pas_pkg::PEDAL_W-1:0]     pedal_index,
	input  logic [pas_pkg::ADC_W-1:0]       adc_sample,
	input  logic [pas_pkg::TIME_W-1:0]      now_ms,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pas_pkg::VAL_W-1:0]       cfg_data,
	output logic                            q_push,
	output pas_pkg::pas_work_t              q_data
);

	logic [pas_pkg::VAL_W-1:0] low_q  [pas_pkg::CAL_PEDALS];
	logic [pas_pkg::VAL_W-1:0] high_q [pas_pkg::CAL_PEDALS];

	logic [pas_pkg::VAL_W-1:0]  cal_a, cal_b, lo, hi;
	logic                       inv;
	logic [pas_pkg::WIDE_W-1:0] v_wide, lo_wide, hi_wide, v_clamp, v_off;
	logic [1:0]                 cfg_pedal;

	assign cfg_ready = 1'b1;
	assign cfg_pedal = cfg_index[pas_pkg::CFG_IDX_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pas_pkg::CAL_PEDALS; i++) begin
				low_q[i]  <= '0;
				high_q[i] <= pas_pkg::VAL_MAX;
			end
		end else if (cfg_valid && cfg_ready
				&& 32'(cfg_index) < pas_pkg::CFG_REG_COUNT) begin
			if (cfg_index[0] == pas_pkg::CFG_SEL_HIGH) begin
				high_q[cfg_pedal] <= cfg_data;
			end else begin
				low_q[cfg_pedal] <= cfg_data;
			end
		end
	end

	// Pedals without registers use the full 0..127 range.
	always_comb begin
		cal_a = '0;
		cal_b = pas_pkg::VAL_MAX;
		if (32'(pedal_index) < pas_pkg::CAL_PEDALS) begin
			cal_a = low_q[pedal_index];
			cal_b = high_q[pedal_index];
		end
	end

	assign inv = cal_a > cal_b;
	assign lo  = inv ? cal_b : cal_a;
	assign hi  = inv ? cal_a : cal_b;

	assign v_wide  = {adc_sample, {pas_pkg::ADC_SHIFT{1'b0}}};
	assign lo_wide = {lo, {pas_pkg::CAL_SHIFT{1'b0}}};
	assign hi_wide = {hi, {pas_pkg::CAL_SHIFT{1'b0}}};

	always_comb begin
		priority if (v_wide < lo_wide) begin
			v_clamp = lo_wide;
		end else if (v_wide > hi_wide) begin
			v_clamp = hi_wide;
		end else begin
			v_clamp = v_wide;
		end
	end

	// The offset is a multiple of 16 and the divisor is (hi - lo) * 4, so
	// dropping two bits from both keeps the quotient exact.
	assign v_off = v_clamp - lo_wide;

	assign q_push          = push && !q_full && (32'(pedal_index) < pas_pkg::PEDAL_COUNT);
	assign q_data.pedal    = pedal_index;
	assign q_data.dividend = v_off[pas_pkg::WIDE_W-1:2];
	assign q_data.divisor  = hi - lo;
	assign q_data.inv      = inv;
	assign q_data.now_ms   = now_ms;

endmodule

`default_nettype wire

### sv/pas_fifo.sv
// Short work queue that decouples the front end from the back end.
`default_nettype none

module pas_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  pas_pkg::pas_work_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output pas_pkg::pas_work_t rd_data,
	output logic               q_empty
);

	pas_pkg::pas_work_t                slot_q [pas_pkg::QDEPTH];
	logic [pas_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [pas_pkg::QCNT_W-1:0]        count_q;
	logic                              do_wr, do_rd;

	assign full    = count_q == pas_pkg::QCNT_W'(pas_pkg::QDEPTH);
	assign q_empty = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == pas_pkg::QPTR_W'(pas_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == pas_pkg::QPTR_W'(pas_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/pas_back.sv
// Back end: iterative divider, sample window, hysteresis decision and result register.
`default_nettype none

module pas_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  pas_pkg::pas_work_t           q_data,
	output logic                         q_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [pas_pkg::PEDAL_W-1:0]  event_pedal,
	output logic [pas_pkg::VAL_W-1:0]    event_value
);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCALE, S_COMMIT} state_t;

	state_t                          state_q;
	pas_pkg::pas_work_t              item_q;
	logic [pas_pkg::DSTEP_W-1:0]     step_q;
	logic [pas_pkg::REM_W-1:0]       rem_q;
	logic [pas_pkg::DIVD_W-1:0]      quo_q;
	logic [pas_pkg::MEM_AW-1:0]      addr_q;
	logic [pas_pkg::VAL_W-1:0]       rd_q;
	logic [pas_pkg::VAL_W-1:0]       val_q;
	logic [pas_pkg::SUM_W-1:0]       sum_new_q;
	logic                            gap_ok_q;
	logic [pas_pkg::WPTR_W-1:0]      ptr_q       [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::WCNT_W-1:0]      fill_q      [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::SUM_W-1:0]       sum_q       [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::VAL_W-1:0]       last_val_q  [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::TIME_W-1:0]      last_time_q [pas_pkg::PEDAL_COUNT];
	logic                            out_valid_q;
	logic [pas_pkg::PEDAL_W-1:0]     out_pedal_q;
	logic [pas_pkg::VAL_W-1:0]       out_value_q;

	logic [pas_pkg::VAL_W-1:0]       win_mem [pas_pkg::MEM_DEPTH];

	logic [pas_pkg::MEM_AW-1:0]      rd_addr;
	logic [pas_pkg::REM_W-1:0]       trial, divs_ext;
	logic                            trial_ge;
	logic [pas_pkg::VAL_W-1:0]       q_sat, v_raw, v_scaled, old_val, avg, bmin, bmax;
	logic [pas_pkg::SUM_W-1:0]       sum_calc;
	logic [pas_pkg::TIME_W-1:0]      elapsed;
	logic                            slot_free, commit, hit, fire;

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	assign rd_addr = pas_pkg::MEM_AW'(q_data.pedal) * pas_pkg::MEM_AW'(pas_pkg::WINDOW_DEPTH)
		+ pas_pkg::MEM_AW'(ptr_q[q_data.pedal]);

	// One restoring division step per cycle.
	assign divs_ext = {1'b0, item_q.divisor};
	assign trial    = {rem_q[pas_pkg::REM_W-2:0], quo_q[pas_pkg::DIVD_W-1]};
	assign trial_ge = trial >= divs_ext;

	// The quotient never exceeds 128; 128 saturates. A zero range gives zero.
	assign q_sat    = (quo_q > pas_pkg::DIVD_W'(pas_pkg::VAL_MAX))
		? pas_pkg::VAL_MAX : quo_q[pas_pkg::VAL_W-1:0];
	assign v_raw    = (item_q.divisor == '0) ? '0 : q_sat;
	assign v_scaled = item_q.inv ? pas_pkg::VAL_MAX - v_raw : v_raw;

	// Until the window has filled, the slot being replaced counts as zero.
	assign old_val  = (fill_q[item_q.pedal] == pas_pkg::WCNT_W'(pas_pkg::WINDOW_DEPTH))
		? rd_q : '0;
	assign sum_calc = sum_q[item_q.pedal] - pas_pkg::SUM_W'(old_val)
		+ pas_pkg::SUM_W'(v_scaled);
	assign elapsed  = item_q.now_ms - last_time_q[item_q.pedal];

	assign avg  = pas_pkg::VAL_W'(sum_new_q >> pas_pkg::AVG_SHIFT);
	assign bmax = (avg < pas_pkg::VAL_MAX) ? avg + 1'b1 : pas_pkg::VAL_MAX;
	assign bmin = (avg != '0) ? avg - 1'b1 : '0;

	assign slot_free = !out_valid_q || pop;
	assign commit    = (state_q == S_COMMIT) && slot_free;
	assign hit       = (val_q < bmin || val_q > bmax || val_q == '0 || val_q == pas_pkg::VAL_MAX)
		&& gap_ok_q && (val_q != last_val_q[item_q.pedal]);
	assign fire      = commit && hit;

	assign empty       = !out_valid_q;
	assign event_pedal = out_pedal_q;
	assign event_value = out_value_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			win_mem[addr_q] <= val_q;
		end
		if (q_pop) begin
			rd_q <= win_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			step_q      <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			addr_q      <= '0;
			val_q       <= '0;
			sum_new_q   <= '0;
			gap_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_pedal_q <= '0;
			out_value_q <= '0;
			for (int i = 0; i < pas_pkg::PEDAL_COUNT; i++) begin
				ptr_q[i]       <= '0;
				fill_q[i]      <= '0;
				sum_q[i]       <= '0;
				last_val_q[i]  <= '0;
				last_time_q[i] <= '0;
			end
		end else begin
			// A new event may replace one that is popped in the same cycle.
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						item_q  <= q_data;
						addr_q  <= rd_addr;
						rem_q   <= '0;
						quo_q   <= q_data.dividend;
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= trial_ge ? trial - divs_ext : trial;
					quo_q  <= {quo_q[pas_pkg::DIVD_W-2:0], trial_ge};
					step_q <= step_q + 1'b1;
					if (step_q == pas_pkg::DSTEP_W'(pas_pkg::DIV_STEPS - 1)) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					val_q     <= v_scaled;
					sum_new_q <= sum_calc;
					gap_ok_q  <= elapsed > pas_pkg::TIME_W'(pas_pkg::MIN_GAP_MS);
					state_q   <= S_COMMIT;
				end
				S_COMMIT: begin
					if (slot_free) begin
						sum_q[item_q.pedal] <= sum_new_q;
						ptr_q[item_q.pedal] <= (ptr_q[item_q.pedal]
							== pas_pkg::WPTR_W'(pas_pkg::WINDOW_DEPTH - 1))
							? '0 : ptr_q[item_q.pedal] + 1'b1;
						if (fill_q[item_q.pedal] != pas_pkg::WCNT_W'(pas_pkg::WINDOW_DEPTH)) begin
							fill_q[item_q.pedal] <= fill_q[item_q.pedal] + 1'b1;
						end
						if (hit) begin
							last_val_q[item_q.pedal]  <= val_q;
							last_time_q[item_q.pedal] <= item_q.now_ms;
							out_pedal_q               <= item_q.pedal;
							out_value_q               <= val_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (step_q < pas_pkg::DSTEP_W'(pas_pkg::DIV_STEPS)))
		else $error("divider ran past its step count");

	a_pedal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (32'(item_q.pedal) < pas_pkg::PEDAL_COUNT))
		else $error("out-of-range pedal reached the back end");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT)
		|-> (fill_q[item_q.pedal] <= pas_pkg::WCNT_W'(pas_pkg::WINDOW_DEPTH)))
		else $error("window fill count exceeds depth");

	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_valid_q && state_q == S_IDLE))
		else $error("event was not placed in the result register");

endmodule

`default_nettype wire

### sv/pedal_adc_scaler_with_hysteresis.sv
// Top level of the pedal ADC scaler with moving-average hysteresis.
//
// Each request carries one 12-bit ADC sample of one of three pedals together with a
// millisecond timestamp. The sample is clamped to the pedal's calibration range (two
// 7-bit end points, swapped and the result inverted when end point B lies below A),
// scaled to 0..127, and pushed into a 16-sample window for that pedal. An event
// (pedal, value) is produced only when the value lies outside the window average
// plus or minus one or sits at 0 or 127, differs from the last value reported for
// that pedal, and more than 20 ms have passed since that pedal's last event. Samples
// for a pedal index of 3 are accepted and dropped. In the back end each sample is
// taken from the work queue while its window slot is read, then scaled by the
// bit-serial divider; after that the scaled value and new window sum are formed,
// and last the window is updated and the event decided. The front end accepts
// requests into a two-entry work queue while the back end is busy, and the back
// end keeps dividing while one event waits on the result side; it holds each
// sample in its final step for as long as an earlier event is still unread.
// Calibration registers are written through the cfg port, which is always ready,
// and should only be written while no request is in flight.
`default_nettype none

module pedal_adc_scaler_with_hysteresis (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [pas_pkg::PEDAL_W-1:0]    pedal_index,
	input  logic [pas_pkg::ADC_W-1:0]      adc_sample,
	input  logic [pas_pkg::TIME_W-1:0]     now_ms,
	output logic                           empty,
	input  logic                           pop,
	output logic [pas_pkg::PEDAL_W-1:0]    event_pedal,
	output logic [pas_pkg::VAL_W-1:0]      event_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pas_pkg::VAL_W-1:0]      cfg_data
);

	// Work items travel from the front end to the back end through this queue.
	logic               q_push, q_pop, q_empty;
	pas_pkg::pas_work_t q_wr_data, q_rd_data;

	// The front end holds the calibration registers and turns a raw sample into
	// a dividend and divisor for the back end's divider.
	pas_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (full),
		.pedal_index (pedal_index),
		.adc_sample  (adc_sample),
		.now_ms      (now_ms),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	// The queue being full is what back-pressures the input side.
	pas_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.q_empty (q_empty)
	);

	// The back end owns the windows, the per-pedal history and the result register.
	pas_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rd_data),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.event_pedal (event_pedal),
		.event_value (event_value)
	);

endmodule

`default_nettype wire

### tb/pedal_adc_scaler_with_hysteresis_tb.sv
// Self-checking testbench for the pedal ADC scaler with moving-average hysteresis.
//
// The bench pushes pedal samples through the queue-style input, writes calibration
// end points through the configuration channel while the block is idle, and pops
// pedal events on the output side. A behavioral model of the scaler lives in this
// module: it keeps its own copy of the calibration, of each pedal's 16-entry window
// and window sum, and of the last value and time reported per pedal. Every accepted
// request is run through that model; its predicted event, or a typed row's given
// event, is queued. Each popped event is compared field by field with the oldest queued one.
//
// The run starts with a short table of directed requests (saturation at full scale,
// the 20 ms gap boundary, timestamp wrap and backwards time, an ignored pedal index,
// equal and reversed end points, and writes to the unused register indexes). Then
// a series of calibration phases follows, each with its own random traffic made of
// per-pedal random walks, jumps, rail values and the odd ignored sample.
module pedal_adc_scaler_with_hysteresis_tb;

	// Configuration register indexes: 2N is end point A of pedal N, 2N+1 is B.
	// Indexes 6 and 7 are decoded to nothing.
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_P0_LO = 3'd0;
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_P0_HI = 3'd1;
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_P1_LO = 3'd2;
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_P1_HI = 3'd3;
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_P2_LO = 3'd4;
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_P2_HI = 3'd5;
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [pas_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	// A pedal index the block accepts and then drops.
	localparam logic [pas_pkg::PEDAL_W-1:0] PEDAL_UNUSED = 2'd3;

	// Each sample keeps the back end busy through its divider steps and up to two more
	// can wait in the work queue; DRAIN_CYCLES of quiet are enough for a sample that
	// produces no event to leave the pipeline.
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_CYCLES = 600;
	localparam int FLOOD_ITEMS = 40;
	localparam int RUN_LIMIT = 500000;

	typedef struct packed {
		logic [pas_pkg::PEDAL_W-1:0] pedal;
		logic [pas_pkg::VAL_W-1:0]   value;
	} pedal_event_t;

	typedef enum logic {ROW_SAMPLE, ROW_CAL_WRITE} row_kind_e;

	// One row of the directed table. For a sample, sel is the pedal and arg the ADC
	// reading; for a calibration write, sel is the register index and arg the data.
	// Where typed is set, fires and ev give the expected outcome directly.
	typedef struct packed {
		row_kind_e                   kind;
		logic [2:0]                  sel;
		logic [pas_pkg::ADC_W-1:0]   arg;
		logic [pas_pkg::TIME_W-1:0]  stamp;
		logic                        typed;
		logic                        fires;
		pedal_event_t                ev;
	} stim_row_t;

	typedef enum logic [1:0] {SINK_STREAM, SINK_RANDOM, SINK_PATTERN, SINK_TRICKLE} sink_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [pas_pkg::PEDAL_W-1:0] pedal_index;
	logic [pas_pkg::ADC_W-1:0] adc_sample;
	logic [pas_pkg::TIME_W-1:0] now_ms;
	logic empty;
	logic pop;
	logic [pas_pkg::PEDAL_W-1:0] event_pedal;
	logic [pas_pkg::VAL_W-1:0] event_value;
	logic cfg_valid;
	logic cfg_ready;
	logic [pas_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pas_pkg::VAL_W-1:0] cfg_data;

	pedal_adc_scaler_with_hysteresis dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pedal_index(pedal_index),
		.adc_sample(adc_sample),
		.now_ms(now_ms),
		.empty(empty),
		.pop(pop),
		.event_pedal(event_pedal),
		.event_value(event_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model state: calibration end points, windows, and the last report per pedal.
	logic [pas_pkg::VAL_W-1:0]  cal_a [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::VAL_W-1:0]  cal_b [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::VAL_W-1:0]  window [pas_pkg::PEDAL_COUNT][pas_pkg::WINDOW_DEPTH];
	logic [15:0]                window_total [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::VAL_W-1:0]  sent_value [pas_pkg::PEDAL_COUNT];
	logic [pas_pkg::TIME_W-1:0] sent_time [pas_pkg::PEDAL_COUNT];

	pedal_event_t pending_events [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	int unsigned flood_left = 0;
	bit hold_off_req = 1'b0;

	// Directed requests. The first rows run on the reset calibration of 0..127 with
	// empty windows and a last report of value 0 at time 0 for every pedal.
	stim_row_t directed_rows [24] = '{
		// Full scale gives a quotient of 128, which saturates to 127.
		'{ROW_SAMPLE, 3'd0, 12'd4095, 32'd100, 1'b1, 1'b1, '{2'd0, pas_pkg::VAL_MAX}},
		// Only 10 ms after the last event: held back.
		'{ROW_SAMPLE, 3'd0, 12'd0, 32'd110, 1'b1, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd0, 12'd0, 32'd200, 1'b1, 1'b1, '{2'd0, 7'd0}},
		// The unused pedal index is swallowed without a trace.
		'{ROW_SAMPLE, {1'b0, PEDAL_UNUSED}, 12'd4095, 32'd300, 1'b1, 1'b0, '{2'd0, 7'd0}},
		// Zero equals the last value reported after reset.
		'{ROW_SAMPLE, 3'd1, 12'd0, 32'd400, 1'b1, 1'b0, '{2'd0, 7'd0}},
		// Exactly 20 ms is not enough; 21 ms is.
		'{ROW_SAMPLE, 3'd1, 12'd4095, 32'd20, 1'b1, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd1, 12'd4095, 32'd21, 1'b1, 1'b1, '{2'd1, pas_pkg::VAL_MAX}},
		// Near the top of the time range, then across the wrap.
		'{ROW_SAMPLE, 3'd2, 12'd4095, 32'hFFFF_FFF0, 1'b1, 1'b1, '{2'd2, pas_pkg::VAL_MAX}},
		'{ROW_SAMPLE, 3'd2, 12'd4095, 32'd5, 1'b1, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd2, 12'd0, 32'd4, 1'b1, 1'b0, '{2'd0, 7'd0}},
		// Time that runs backwards counts as a long gap.
		'{ROW_SAMPLE, 3'd0, 12'd4095, 32'd150, 1'b1, 1'b1, '{2'd0, pas_pkg::VAL_MAX}},
		'{ROW_SAMPLE, 3'd0, 12'd2048, 32'd400, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd0, 12'd2100, 32'd420, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd1, 12'd1024, 32'd500, 1'b0, 1'b0, '{2'd0, 7'd0}},
		// Equal end points scale everything to zero.
		'{ROW_CAL_WRITE, REG_P0_LO, 12'd60, 32'd0, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_CAL_WRITE, REG_P0_HI, 12'd60, 32'd0, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd0, 12'd4095, 32'd1000, 1'b1, 1'b1, '{2'd0, 7'd0}},
		// Fully reversed range: full scale reads as zero.
		'{ROW_CAL_WRITE, REG_P1_LO, 12'd127, 32'd0, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_CAL_WRITE, REG_P1_HI, 12'd0, 32'd0, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd1, 12'd4095, 32'd1000, 1'b1, 1'b1, '{2'd1, 7'd0}},
		// The unused register indexes must leave pedal 2 on its reset range.
		'{ROW_CAL_WRITE, REG_SPARE6, 12'h055, 32'd0, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_CAL_WRITE, REG_SPARE7, 12'h02A, 32'd0, 1'b0, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd2, 12'd4095, 32'd2000, 1'b1, 1'b0, '{2'd0, 7'd0}},
		'{ROW_SAMPLE, 3'd2, 12'd0, 32'd2000, 1'b1, 1'b1, '{2'd2, 7'd0}}
	};

	// Clamp the widened sample to the pedal's range, scale it to 0..127, and invert
	// it when the end points are reversed.
	function automatic logic [pas_pkg::VAL_W-1:0] scaled_position(
			input logic [pas_pkg::PEDAL_W-1:0] p, input logic [pas_pkg::ADC_W-1:0] adc);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] pos;
		logic [31:0] step;
		logic swap;
		swap = cal_a[p] > cal_b[p];
		lo = swap ? 32'(cal_b[p]) : 32'(cal_a[p]);
		hi = swap ? 32'(cal_a[p]) : 32'(cal_b[p]);
		lo = lo << pas_pkg::CAL_SHIFT;
		hi = hi << pas_pkg::CAL_SHIFT;
		pos = 32'(adc) << pas_pkg::ADC_SHIFT;
		if (pos < lo)
			pos = lo;
		if (pos > hi)
			pos = hi;
		pos = pos - lo;
		step = (hi - lo) >> pas_pkg::VAL_W;
		pos = (step == 0) ? 32'd0 : pos / step;
		if (pos > 32'h8000)
			pos = 32'd0;
		else if (pos > 32'(pas_pkg::VAL_MAX))
			pos = 32'(pas_pkg::VAL_MAX);
		if (swap)
			pos = 32'(pas_pkg::VAL_MAX) - pos;
		return pos[pas_pkg::VAL_W-1:0];
	endfunction

	// Advance the model by one accepted sample. Returns 1 when the sample produces
	// an event, which is then handed back through ev.
	function automatic bit pedal_step(input logic [pas_pkg::PEDAL_W-1:0] p,
			input logic [pas_pkg::ADC_W-1:0] adc, input logic [pas_pkg::TIME_W-1:0] stamp,
			output pedal_event_t ev);
		logic [pas_pkg::VAL_W-1:0] val;
		logic [15:0] avg;
		logic [15:0] upper;
		logic [15:0] lower;
		logic [pas_pkg::TIME_W-1:0] elapsed;
		ev = '0;
		if (p >= pas_pkg::PEDAL_COUNT)
			return 1'b0;
		val = scaled_position(p, adc);
		window_total[p] = window_total[p] - 16'(window[p][pas_pkg::WINDOW_DEPTH-1])
			+ 16'(val);
		for (int j = pas_pkg::WINDOW_DEPTH - 1; j > 0; j--)
			window[p][j] = window[p][j-1];
		window[p][0] = val;
		avg = window_total[p] / pas_pkg::WINDOW_DEPTH;
		upper = (avg < 16'(pas_pkg::VAL_MAX)) ? avg + 16'd1 : 16'(pas_pkg::VAL_MAX);
		lower = (avg >= 16'd1) ? avg - 16'd1 : 16'd0;
		elapsed = stamp - sent_time[p];
		if ((16'(val) < lower || 16'(val) > upper || val == '0 || val == pas_pkg::VAL_MAX) &&
				elapsed > pas_pkg::TIME_W'(pas_pkg::MIN_GAP_MS) && sent_value[p] != val) begin
			sent_value[p] = val;
			sent_time[p] = stamp;
			ev.pedal = p;
			ev.value = val;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offer one sample and wait until the block takes it. The sender works in bursts
	// with random gaps between them, except during a flood, when it never pauses.
	// A typed row supplies its own expected outcome; the model still runs on it so
	// that its state keeps up with the block.
	task automatic offer_sample(input logic [pas_pkg::PEDAL_W-1:0] p,
			input logic [pas_pkg::ADC_W-1:0] adc, input logic [pas_pkg::TIME_W-1:0] stamp,
			input bit typed, input bit fires, input pedal_event_t typed_ev);
		pedal_event_t ev;
		bit fired;
		int unsigned gap;
		cfg_valid <= 1'b0;
		if (flood_left != 0) begin
			flood_left--;
		end else if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end else begin
			burst_left--;
		end
		push <= 1'b1;
		pedal_index <= p;
		adc_sample <= adc;
		now_ms <= stamp;
		@(posedge clk);
		while (full)
			@(posedge clk);
		fired = pedal_step(p, adc, stamp, ev);
		if (typed) begin
			if (fires)
				pending_events.push_back(typed_ev);
		end else if (fired) begin
			pending_events.push_back(ev);
		end
	endtask

	// Write one calibration register and mirror it in the model. Valid is left high
	// so that back-to-back writes keep it asserted; the next sample lowers it.
	task automatic write_cal(input logic [pas_pkg::CFG_IDX_W-1:0] idx,
			input logic [pas_pkg::VAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_P0_LO: cal_a[0] = data;
			REG_P0_HI: cal_b[0] = data;
			REG_P1_LO: cal_a[1] = data;
			REG_P1_HI: cal_b[1] = data;
			REG_P2_LO: cal_a[2] = data;
			REG_P2_HI: cal_b[2] = data;
			default: ;
		endcase
	endtask

	// Stop sending and wait until every predicted event has been popped, then give
	// samples that produce no event time to leave the pipeline.
	task automatic settle();
		push <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_event(input logic [pas_pkg::PEDAL_W-1:0] got_pedal,
			input logic [pas_pkg::VAL_W-1:0] got_value);
		pedal_event_t want;
		if (pending_events.size() == 0) begin
			$error("event with nothing pending: pedal %0d value %0d", got_pedal, got_value);
			mismatches++;
			return;
		end
		want = pending_events.pop_front();
		if (got_pedal !== want.pedal) begin
			$error("event_pedal mismatch: expected %0d, got %0d", want.pedal, got_pedal);
			mismatches++;
		end
		if (got_value !== want.value) begin
			$error("event_value mismatch: expected %0d, got %0d", want.value, got_value);
			mismatches++;
		end
	endtask

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Event receiver. It switches at random between four stall behaviors: popping
	// every cycle, popping at random, popping on a fixed one-in-four pattern, or
	// popping only rarely. When the sender asks for it, the receiver holds off
	// completely for a long stretch so that the block backs up all the way to its
	// input.
	initial begin : event_sink
		sink_mode_e mode;
		int unsigned mode_left;
		int unsigned tick;
		mode = SINK_STREAM;
		mode_left = 0;
		tick = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_event(event_pedal, event_value);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = sink_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			tick++;
			case (mode)
				SINK_STREAM: pop <= 1'b1;
				SINK_RANDOM: pop <= 1'($urandom_range(0, 1));
				SINK_PATTERN: pop <= (tick % 4 == 0);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Request sender: reset, the directed table, then the calibration phases.
	initial begin : sample_source
		stim_row_t row;
		bit idle_now;
		logic [pas_pkg::ADC_W-1:0] walk [pas_pkg::PEDAL_COUNT];
		logic [pas_pkg::TIME_W-1:0] clock_ms;
		logic [pas_pkg::PEDAL_W-1:0] p;
		logic [pas_pkg::ADC_W-1:0] adc;
		logic [pas_pkg::VAL_W-1:0] lo;
		logic [pas_pkg::VAL_W-1:0] hi;
		int unsigned roll;
		int unsigned issued;
		int signed moved;
		arst_n <= 1'b0;
		push <= 1'b0;
		pedal_index <= '0;
		adc_sample <= '0;
		now_ms <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		for (int q = 0; q < pas_pkg::PEDAL_COUNT; q++) begin
			cal_a[q] = '0;
			cal_b[q] = pas_pkg::VAL_MAX;
			window_total[q] = '0;
			sent_value[q] = '0;
			sent_time[q] = '0;
			walk[q] = 12'd2048;
			for (int j = 0; j < pas_pkg::WINDOW_DEPTH; j++)
				window[q][j] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Calibration writes in the table are only issued once the block is idle.
		idle_now = 1'b1;
		for (int r = 0; r < $size(directed_rows); r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_CAL_WRITE) begin
				if (!idle_now)
					settle();
				idle_now = 1'b1;
				write_cal(row.sel, row.arg[pas_pkg::VAL_W-1:0]);
			end else begin
				offer_sample(row.sel[pas_pkg::PEDAL_W-1:0], row.arg, row.stamp, row.typed,
					row.fires, row.ev);
				idle_now = 1'b0;
			end
		end

		// Each phase waits for the block to drain, sets all three ranges, and then
		// runs random traffic. The first phases pin the ranges to their extremes:
		// full forward, full reversed, equal end points, and one-step ranges.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			for (int q = 0; q < pas_pkg::PEDAL_COUNT; q++) begin
				case (ph)
					0: begin
						lo = '0;
						hi = pas_pkg::VAL_MAX;
					end
					1: begin
						lo = pas_pkg::VAL_MAX;
						hi = '0;
					end
					2: begin
						lo = (q == 0) ? 7'd0 : (q == 1) ? pas_pkg::VAL_MAX
							: 7'($urandom_range(1, 126));
						hi = lo;
					end
					3: begin
						lo = 7'($urandom_range(1, 126));
						hi = (q == 1) ? lo - 7'd1 : lo + 7'd1;
					end
					default: begin
						lo = 7'($urandom_range(0, 127));
						hi = ($urandom_range(0, 9) == 0) ? lo : 7'($urandom_range(0, 127));
					end
				endcase
				case (q)
					0: begin
						write_cal(REG_P0_LO, lo);
						write_cal(REG_P0_HI, hi);
					end
					1: begin
						write_cal(REG_P1_LO, lo);
						write_cal(REG_P1_HI, hi);
					end
					default: begin
						write_cal(REG_P2_LO, lo);
						write_cal(REG_P2_HI, hi);
					end
				endcase
			end
			write_cal(REG_SPARE6, 7'($urandom_range(0, 127)));
			write_cal(REG_SPARE7, 7'($urandom_range(0, 127)));

			// One phase starts just below the top of the time range so that the
			// millisecond counter wraps while events are flowing.
			clock_ms = (ph == 4) ? 32'hFFFF_FC00 : 32'($urandom());
			issued = 0;
			while (issued < ITEMS_PER_PHASE) begin
				// Twice in the run, the receiver stops for a long time while the
				// sender keeps pushing without a break.
				if ((ph == 2 || ph == 6) && issued == 60) begin
					hold_off_req = 1'b1;
					flood_left = FLOOD_ITEMS;
				end

				// Mostly small time steps so that the 20 ms gap matters, sometimes
				// longer ones, and now and then a jump anywhere, which may go back.
				roll = $urandom_range(0, 99);
				if (roll < 70)
					clock_ms = clock_ms + 32'($urandom_range(0, 12));
				else if (roll < 95)
					clock_ms = clock_ms + 32'($urandom_range(13, 45));
				else
					clock_ms = 32'($urandom());

				// Each pedal follows a random walk with occasional jumps and rail
				// values; a few samples go to the unused pedal index.
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					p = PEDAL_UNUSED;
					adc = 12'($urandom_range(0, 4095));
				end else begin
					p = 2'($urandom_range(0, pas_pkg::PEDAL_COUNT - 1));
					roll = $urandom_range(0, 99);
					if (roll < 60) begin
						moved = int'(walk[p]) + $signed($urandom_range(0, 320)) - 160;
						if (moved < 0)
							moved = 0;
						if (moved > 4095)
							moved = 4095;
						walk[p] = 12'(moved);
					end else if (roll < 72) begin
						walk[p] = 12'($urandom_range(0, 4095));
					end else if (roll < 84) begin
						walk[p] = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'd4095;
					end
					adc = walk[p];
					issued++;
				end
				offer_sample(p, adc, clock_ms, 1'b0, 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
